### rtl/twtp_pkg.sv
// Package: constants, codes and record types of the timing wheel timer pool.
package twtp_pkg;

    // Wheel geometry and pool size
    localparam int SLOTS     = 60;
    localparam int TICK_UNIT = 1;
    localparam int ENTRIES   = 32;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int TIME_W   = 24;
    localparam int ENTRY_W  = 5;
    localparam int SLOT_W   = 6;
    localparam int ROUNDS_W = 18;
    localparam int KIND_W   = 3;

    // Stream widths, padded to whole bytes
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;
    localparam int OUT_PAD = OUT_W - (ENTRY_W + SLOT_W + ROUNDS_W);

    // Rotation count saturates at the field maximum
    localparam int ROT_MAX = (2 ** ROUNDS_W) - 1;

    // Constant division by reciprocal multiply: for any x below 2**TIME_W,
    // x / d == (x * M) >> (TIME_W + L), L = clog2(d), M = ceil(2**(TIME_W+L) / d)
    localparam int     RECIP_W  = TIME_W + 1;
    localparam int     PROD_W   = TIME_W + RECIP_W;
    localparam int     TU_SHIFT = TIME_W + $clog2(TICK_UNIT);
    localparam int     SL_SHIFT = TIME_W + $clog2(SLOTS);
    localparam longint TU_RECIP = ((longint'(1) << TU_SHIFT) + TICK_UNIT - 1) / TICK_UNIT;
    localparam longint SL_RECIP = ((longint'(1) << SL_SHIFT) + SLOTS - 1) / SLOTS;
    localparam int     REM_W    = $clog2(SLOTS);
    localparam int     STEP_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED   = 3'd0,
        KIND_BAD     = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_DELETED = 3'd3,
        KIND_UNUSED  = 3'd4,
        KIND_EXPIRED = 3'd5,
        KIND_DONE    = 3'd6
    } t_kind;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rot;
    } t_mem_word;

    typedef struct packed {
        t_kind               kind;
        logic [ENTRY_W-1:0]  entry;
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
        logic                last;
    } t_result;

endpackage

### rtl/timing_wheel_timer_pool.sv
// Top level: single-level timing wheel over a fixed pool of timer entries.
//
// Timing wheel with twtp_pkg::SLOTS slots over a pool of twtp_pkg::ENTRIES timers.
// The input stream carries add, delete and tick requests (action on tuser); one
// request is taken at a time and s_axis_tready is high only while the block is idle.
// Add walks the valid bits one entry per cycle for the lowest free entry, then uses
// one shared reciprocal multiplier twice, timeout / TICK_UNIT and then ticks /
// SLOTS, and then forms ticks mod SLOTS before the entry is written. Add on a full
// pool reports once every entry is found valid. Delete or a negative timeout report
// through the pending-result state. Tick reads the entry memory one entry per cycle
// through its single registered read port while no expiry waits on m_axis_tready.
// Any request holds while a new result waits on m_axis_tready. Results sit in an
// output register, so a new request is taken while the last result waits. Every
// request that yields results ends with m_axis_tlast high; the unknown action
// yields none. Entry slot and rotation live in a memory with no reset; only valid
// bits reset.
module timing_wheel_timer_pool (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [twtp_pkg::IN_W-1:0]   s_axis_tdata,   // timeout[23:0], handle[28:24]
    input  logic [twtp_pkg::ACT_W-1:0]  s_axis_tuser,   // action[1:0]
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [twtp_pkg::OUT_W-1:0]  m_axis_tdata,   // entry[4:0], slot[10:5], rounds[28:11]
    output logic [twtp_pkg::KIND_W-1:0] m_axis_tuser,   // kind[2:0]
    output logic                        m_axis_tlast    // last result of the request
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FREE = 7'b0000010,   // search lowest free entry
        ST_DIV  = 7'b0000100,   // shared multiplier: ticks, rounds, remainder
        ST_ADD  = 7'b0001000,   // write entry, report handle
        ST_TICK = 7'b0010000,   // scan pool, one entry a cycle unless an expiry waits on the output
        ST_DONE = 7'b0100000,   // tick done, advance wheel
        ST_EMIT = 7'b1000000    // single pending result
    } t_state;

    localparam logic [twtp_pkg::ENTRY_W-1:0] LAST_IDX = twtp_pkg::ENTRY_W'(twtp_pkg::ENTRIES - 1);
    // divide sequence steps
    localparam logic [twtp_pkg::STEP_W-1:0]  STEP_TICKS  = 2'd0;
    localparam logic [twtp_pkg::STEP_W-1:0]  STEP_ROUNDS = 2'd1;

    t_state                         r_state, n_state;
    logic [twtp_pkg::ENTRIES-1:0]   r_valid, n_valid;
    logic [twtp_pkg::SLOT_W-1:0]    r_cur, n_cur;
    logic [twtp_pkg::ENTRY_W-1:0]   r_idx, n_idx;
    logic [twtp_pkg::ENTRY_W-1:0]   r_free, n_free;
    logic [twtp_pkg::STEP_W-1:0]    r_step, n_step;
    logic [twtp_pkg::TIME_W-1:0]    r_quo, n_quo;
    logic [twtp_pkg::TIME_W-1:0]    r_num, n_num;
    logic [twtp_pkg::REM_W-1:0]     r_rem, n_rem;
    twtp_pkg::t_result              r_res, n_res;
    logic                           r_out_valid;
    twtp_pkg::t_result              r_out;

    // entry memory
    twtp_pkg::t_mem_word            mem [twtp_pkg::ENTRIES];
    twtp_pkg::t_mem_word            r_rd;
    logic [twtp_pkg::ENTRY_W-1:0]   rd_addr;
    logic                           we;
    logic [twtp_pkg::ENTRY_W-1:0]   waddr;
    twtp_pkg::t_mem_word            wdata;

    // result push
    logic                           emit;
    twtp_pkg::t_result              res;
    logic                           out_free;

    // input fields
    twtp_pkg::t_action              in_act;
    logic [twtp_pkg::TIME_W-1:0]    in_time;
    logic [twtp_pkg::ENTRY_W-1:0]   in_handle;

    // shared multiplier datapath
    logic [twtp_pkg::RECIP_W-1:0]   mul_k;
    logic [twtp_pkg::PROD_W-1:0]    mul_p;
    logic [twtp_pkg::TIME_W-1:0]    mul_q;
    logic [twtp_pkg::TIME_W-1:0]    rem_full;

    // add / tick helpers
    logic [twtp_pkg::SLOT_W:0]      slot_sum;
    logic [twtp_pkg::SLOT_W-1:0]    add_slot;
    logic [twtp_pkg::ROUNDS_W-1:0]  add_rot;
    logic                           tick_hit;
    logic                           tick_expire;
    logic                           tick_adv;

    assign in_act    = twtp_pkg::t_action'(s_axis_tuser);
    assign in_time   = s_axis_tdata[twtp_pkg::TIME_W-1:0];
    assign in_handle = s_axis_tdata[twtp_pkg::TIME_W+twtp_pkg::ENTRY_W-1:twtp_pkg::TIME_W];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // reciprocal multiply: first step divides by TICK_UNIT, second by SLOTS
    assign mul_k    = (r_step == STEP_TICKS) ? twtp_pkg::RECIP_W'(twtp_pkg::TU_RECIP)
                                             : twtp_pkg::RECIP_W'(twtp_pkg::SL_RECIP);
    assign mul_p    = twtp_pkg::PROD_W'(r_quo) * twtp_pkg::PROD_W'(mul_k);
    assign mul_q    = (r_step == STEP_TICKS) ? twtp_pkg::TIME_W'(mul_p >> twtp_pkg::TU_SHIFT)
                                             : twtp_pkg::TIME_W'(mul_p >> twtp_pkg::SL_SHIFT);
    // ticks mod SLOTS from ticks and the quotient
    assign rem_full = r_num - r_quo * twtp_pkg::TIME_W'(twtp_pkg::SLOTS);

    // slot = (current + ticks mod SLOTS) mod SLOTS; both terms are below SLOTS
    assign slot_sum = {1'b0, r_cur} + (twtp_pkg::SLOT_W+1)'(r_rem);
    assign add_slot = (slot_sum >= (twtp_pkg::SLOT_W+1)'(twtp_pkg::SLOTS))
                    ? twtp_pkg::SLOT_W'(slot_sum - (twtp_pkg::SLOT_W+1)'(twtp_pkg::SLOTS))
                    : slot_sum[twtp_pkg::SLOT_W-1:0];
    assign add_rot  = (r_quo > twtp_pkg::TIME_W'(twtp_pkg::ROT_MAX))
                    ? twtp_pkg::ROUNDS_W'(twtp_pkg::ROT_MAX)
                    : r_quo[twtp_pkg::ROUNDS_W-1:0];

    // tick scan: r_rd holds the entry at r_idx
    assign tick_hit    = r_valid[r_idx] && (r_rd.slot == r_cur);
    assign tick_expire = tick_hit && (r_rd.rot == '0);
    assign tick_adv    = !tick_expire || out_free;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_free  = r_free;
        n_step  = r_step;
        n_quo   = r_quo;
        n_num   = r_num;
        n_rem   = r_rem;
        n_res   = r_res;
        emit    = 1'b0;
        res     = r_res;
        we      = 1'b0;
        waddr   = r_free;
        wdata   = r_rd;
        rd_addr = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res = '{kind: twtp_pkg::KIND_BAD, entry: '0, slot: '0, rounds: '0,
                              last: 1'b1};
                    unique case (in_act)
                        twtp_pkg::ACT_ADD: begin
                            if (in_time[twtp_pkg::TIME_W-1]) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_quo   = in_time;
                                n_step  = STEP_TICKS;
                                n_state = ST_FREE;
                            end
                        end
                        twtp_pkg::ACT_DELETE: begin
                            if ((32'(in_handle) < twtp_pkg::ENTRIES) && r_valid[in_handle]) begin
                                n_valid[in_handle] = 1'b0;
                                n_res.kind  = twtp_pkg::KIND_DELETED;
                                n_res.entry = in_handle;
                            end else begin
                                n_res.kind  = twtp_pkg::KIND_UNUSED;
                            end
                            n_state = ST_EMIT;
                        end
                        twtp_pkg::ACT_TICK: begin
                            n_idx   = '0;
                            n_state = ST_TICK;
                        end
                        twtp_pkg::ACT_NONE: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_FREE: begin
                if (!r_valid[r_idx]) begin
                    n_free  = r_idx;
                    n_state = ST_DIV;
                end else if (r_idx == LAST_IDX) begin
                    n_res.kind = twtp_pkg::KIND_FULL;
                    n_state    = ST_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_DIV: begin
                n_step = r_step + 1'b1;
                unique case (r_step)
                    STEP_TICKS: begin
                        // ticks = max(1, timeout / TICK_UNIT)
                        n_quo = (mul_q == '0) ? twtp_pkg::TIME_W'(1) : mul_q;
                    end
                    STEP_ROUNDS: begin
                        n_num = r_quo;
                        n_quo = mul_q;
                    end
                    default: begin
                        // ticks mod SLOTS, always below SLOTS
                        n_rem   = rem_full[twtp_pkg::REM_W-1:0];
                        n_state = ST_ADD;
                    end
                endcase
            end

            ST_ADD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    res     = '{kind: twtp_pkg::KIND_ADDED, entry: r_free, slot: add_slot,
                                rounds: add_rot, last: 1'b1};
                    we      = 1'b1;
                    waddr   = r_free;
                    wdata   = '{slot: add_slot, rot: add_rot};
                    n_valid[r_free] = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_TICK: begin
                rd_addr = r_idx;
                if (tick_adv) begin
                    if (tick_hit && !tick_expire) begin
                        we    = 1'b1;
                        waddr = r_idx;
                        wdata = '{slot: r_rd.slot, rot: r_rd.rot - 1'b1};
                    end
                    if (tick_expire) begin
                        emit = 1'b1;
                        res  = '{kind: twtp_pkg::KIND_EXPIRED, entry: r_idx, slot: r_cur,
                                 rounds: '0, last: 1'b0};
                        n_valid[r_idx] = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        rd_addr = '0;
                        n_state = ST_DONE;
                    end else begin
                        rd_addr = r_idx + 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    res     = '{kind: twtp_pkg::KIND_DONE, entry: '0, slot: r_cur,
                                rounds: '0, last: 1'b1};
                    n_cur   = (r_cur == twtp_pkg::SLOT_W'(twtp_pkg::SLOTS - 1))
                            ? '0 : r_cur + 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    res     = r_res;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // entry memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cur   <= n_cur;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_free <= n_free;
        r_step <= n_step;
        r_quo  <= n_quo;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_res  <= n_res;
        if (emit) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{twtp_pkg::OUT_PAD{1'b0}}, r_out.rounds, r_out.slot, r_out.entry};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    // wheel position stays inside the wheel
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < twtp_pkg::SLOTS)
        else $error("current slot out of range");

    // a completed add claims exactly one entry
    a_add_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && out_free) |=>
            $countones(r_valid) == $past($countones(r_valid)) + 1)
        else $error("add did not claim one entry");

    // an expiry frees the entry it reports
    a_expire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && tick_expire && out_free) |=> !r_valid[$past(r_idx)])
        else $error("expired entry still valid");

    // wheel advances only when the tick closes
    a_cur_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_DONE && out_free) |=> $stable(r_cur))
        else $error("current slot moved outside tick done");

    // expiries are never the final result of a tick
    a_expire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == twtp_pkg::KIND_EXPIRED) |-> !m_axis_tlast)
        else $error("expired result marked last");

endmodule
